// ===== hdl/pges_pkg.sv =====
package pges_pkg;

    localparam int CoordW = 32;
    localparam int MassW  = 32;
    localparam int DtW    = 16;
    localparam int GW     = 16;
    localparam int MagW   = 33;   // magnitude of a coordinate difference
    localparam int AccW   = 100;  // widest product: r cubed or the numerator
    localparam int DenW   = 99;
    localparam int QW     = 34;
    localparam int DivSteps = 132; // accumulator bits plus the extra fraction shift

    typedef enum logic [1:0] {
        OP_PULL   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_RELOAD = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_COINCIDE  = 2'd1,
        ST_ZERO_MASS = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_VEL_X = 3'd2,
        CFG_VEL_Y = 3'd3,
        CFG_MASS  = 3'd4,
        CFG_GRAV  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [CoordW-1:0] other_pos_x;
        logic signed [CoordW-1:0] other_pos_y;
        logic [MassW-1:0]         other_mass;
        logic [DtW-1:0]           time_step;
    } t_in_word;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] vel_x;
        logic signed [CoordW-1:0] vel_y;
        logic [1:0]               status;
    } t_out_word;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DIFF  = 14'b00000000000010,
        S_R2X   = 14'b00000000000100,
        S_R2Y   = 14'b00000000001000,
        S_SQRT  = 14'b00000000010000,
        S_RSQ   = 14'b00000000100000,
        S_RCUBE = 14'b00000001000000,
        S_NG    = 14'b00000010000000,
        S_NM    = 14'b00000100000000,
        S_NT    = 14'b00001000000000,
        S_DIV   = 14'b00010000000000,
        S_ADDV  = 14'b00100000000000,
        S_MOVE  = 14'b01000000000000,
        S_ADDP  = 14'b10000000000000
    } t_state;

    // saturating add of a signed magnitude; top bit flags saturation
    function automatic logic [CoordW:0] sat_add(input logic [CoordW-1:0] a,
                                                input logic [QW-1:0] mag,
                                                input logic neg);
        logic signed [QW+1:0] d;
        logic signed [QW+1:0] s;
        logic signed [QW+1:0] hi;
        logic signed [QW+1:0] lo;
        d  = $signed({2'b00, mag});
        if (neg) begin
            d = -d;
        end
        s  = $signed({{(QW+2-CoordW){a[CoordW-1]}}, a}) + d;
        hi = $signed({{(QW+3-CoordW){1'b0}}, {(CoordW-1){1'b1}}});
        lo = -hi - $signed((QW+2)'(1));
        if (s > hi) begin
            sat_add = {1'b1, 1'b0, {(CoordW-1){1'b1}}};
        end else if (s < lo) begin
            sat_add = {1'b1, 1'b1, {(CoordW-1){1'b0}}};
        end else begin
            sat_add = {1'b0, s[CoordW-1:0]};
        end
    endfunction

endpackage

// ===== hdl/pairwise_gravity_euler_step_top.sv =====
// channel  | valid        | stall        | word
// ---------+--------------+--------------+-------------
// input    | i_in_valid   | o_in_stall   | i_in_word
// result   | o_out_valid  | i_out_stall  | o_out_word
// config   | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// reload and the unused code go straight to the closing position step; a pull
// uses a shift-add multiplier one bit a cycle, a bit-pair square root and a
// restoring divider one bit a cycle per axis
// synchronous active-low reset clears the body state and the reload values and
// sets own mass to 1 and G to 15; the input is stalled while an item is at work;
// a finished word may wait in the output register while the next item is accepted and worked on
module pairwise_gravity_euler_step_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pges_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pges_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int CW = pges_pkg::CoordW;
    localparam int AW = pges_pkg::AccW;
    localparam int MW = pges_pkg::MagW;
    localparam int DW = pges_pkg::DenW;
    localparam int QW = pges_pkg::QW;

    pges_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_ipx, r_ipy, r_ivx, r_ivy;
    logic [pges_pkg::MassW-1:0] r_own_mass;
    logic [pges_pkg::GW-1:0]    r_grav;

    logic [CW-1:0] r_px, r_py, r_vx, r_vy, n_px, n_py, n_vx, n_vy;

    logic [CW-1:0] r_ox, r_oy;
    logic [pges_pkg::MassW-1:0] r_mass;
    logic [pges_pkg::DtW-1:0]   r_dt;

    logic [AW-1:0] r_acc, n_acc, r_mcand, n_mcand;
    logic [MW-1:0] r_mplier, n_mplier;
    logic [7:0]    r_cnt, n_cnt;

    logic [MW-1:0] r_ax, r_ay, n_ax, n_ay;
    logic          r_negx, r_negy, n_negx, n_negy, r_neg, n_neg;
    logic          r_axis, n_axis;

    logic [2*MW-1:0] r_sq, n_sq;
    logic [MW+2:0]   r_srem, n_srem;
    logic [MW-1:0]   r_root, n_root;

    logic [DW-1:0] r_den, n_den;
    logic [AW-1:0] r_drem, n_drem;
    logic [QW-1:0] r_q, n_q;
    logic          r_big, n_big;

    logic          r_sat, n_sat;
    logic [1:0]    r_skip, n_skip;

    pges_pkg::t_out_word r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          in_take, out_take, out_free;
    logic [AW-1:0] mul_acc;
    logic [MW+2:0] s_remt, s_trial;
    logic          s_ge;
    logic [AW-1:0] d_remt;
    logic          d_ge;
    logic [QW-1:0] q_clamp;
    logic [CW:0]   sat_res;
    logic [MW:0]   dxe, dye;
    logic [MW-1:0] vmag_x, vmag_y;

    assign o_in_stall  = (r_state != pges_pkg::S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign mul_acc = r_acc + (r_mplier[0] ? r_mcand : '0);

    assign s_remt  = {r_srem[MW:0], r_sq[2*MW-1 -: 2]};
    assign s_trial = {1'b0, r_root, 2'b01};
    assign s_ge    = (s_remt >= s_trial);

    assign d_remt  = {r_drem[AW-2:0], r_acc[AW-1]};
    assign d_ge    = (d_remt >= {1'b0, r_den});

    assign q_clamp = (r_big || (r_q > (QW'(1) << CW))) ? (QW'(1) << CW) : r_q;

    assign dxe = {r_ox[CW-1], r_ox[CW-1], r_ox} - {r_px[CW-1], r_px[CW-1], r_px};
    assign dye = {r_oy[CW-1], r_oy[CW-1], r_oy} - {r_py[CW-1], r_py[CW-1], r_py};
    assign vmag_x = r_vx[CW-1] ? (MW'(0) - {r_vx[CW-1], r_vx}) : {1'b0, r_vx};
    assign vmag_y = r_vy[CW-1] ? (MW'(0) - {r_vy[CW-1], r_vy}) : {1'b0, r_vy};

    always_comb begin
        if (r_state == pges_pkg::S_ADDV) begin
            sat_res = pges_pkg::sat_add(r_axis ? r_vy : r_vx, q_clamp,
                                        r_axis ? r_negy : r_negx);
        end else begin
            sat_res = pges_pkg::sat_add(r_axis ? r_py : r_px, r_q, r_neg);
        end
    end

    always_comb begin
        n_state = r_state;
        n_px = r_px; n_py = r_py; n_vx = r_vx; n_vy = r_vy;
        n_acc = r_acc; n_mcand = r_mcand; n_mplier = r_mplier; n_cnt = r_cnt;
        n_ax = r_ax; n_ay = r_ay; n_negx = r_negx; n_negy = r_negy;
        n_neg = r_neg; n_axis = r_axis;
        n_sq = r_sq; n_srem = r_srem; n_root = r_root;
        n_den = r_den; n_drem = r_drem; n_q = r_q; n_big = r_big;
        n_sat = r_sat; n_skip = r_skip;
        n_out = r_out;
        n_out_valid = r_out_valid && !out_take;

        unique case (r_state)
            pges_pkg::S_IDLE: begin
                if (in_take) begin
                    n_sat  = 1'b0;
                    n_skip = pges_pkg::ST_DONE;
                    unique case (pges_pkg::t_op'(i_in_word.operation))
                        pges_pkg::OP_PULL: n_state = pges_pkg::S_DIFF;
                        pges_pkg::OP_MOVE: begin
                            n_acc    = '0;
                            n_mcand  = AW'(vmag_x);
                            n_mplier = MW'(i_in_word.time_step);
                            n_cnt    = 8'(pges_pkg::DtW - 1);
                            n_neg    = r_vx[CW-1];
                            n_axis   = 1'b0;
                            n_state  = pges_pkg::S_MOVE;
                        end
                        pges_pkg::OP_RELOAD: begin
                            n_px = r_ipx; n_py = r_ipy; n_vx = r_ivx; n_vy = r_ivy;
                            n_state = pges_pkg::S_IDLE;
                            n_state = pges_pkg::S_ADDP;
                            n_q     = '0;
                            n_axis  = 1'b1;
                            n_neg   = 1'b0;
                        end
                        pges_pkg::OP_NONE: begin
                            n_state = pges_pkg::S_ADDP;
                            n_q     = '0;
                            n_axis  = 1'b1;
                            n_neg   = 1'b0;
                        end
                        default: n_state = pges_pkg::S_IDLE;
                    endcase
                end
            end
            pges_pkg::S_DIFF: begin
                n_negx   = dxe[MW];
                n_negy   = dye[MW];
                n_ax     = dxe[MW] ? MW'(-dxe) : dxe[MW-1:0];
                n_ay     = dye[MW] ? MW'(-dye) : dye[MW-1:0];
                n_acc    = '0;
                n_mcand  = AW'(n_ax);
                n_mplier = n_ax;
                n_cnt    = 8'(MW - 1);
                n_state  = pges_pkg::S_R2X;
            end
            pges_pkg::S_SQRT: begin
                n_sq   = {r_sq[2*MW-3:0], 2'b00};
                n_srem = s_ge ? (s_remt - s_trial) : s_remt;
                n_root = {r_root[MW-2:0], s_ge};
                n_cnt  = r_cnt - 8'd1;
                if (r_cnt == 8'd0) begin
                    if (n_root == '0) begin
                        n_skip  = pges_pkg::ST_COINCIDE;
                        n_state = pges_pkg::S_IDLE;
                        n_state = pges_pkg::S_ADDP;
                        n_q = '0; n_axis = 1'b1; n_neg = 1'b0;
                    end else if (r_own_mass == '0) begin
                        n_skip  = pges_pkg::ST_ZERO_MASS;
                        n_state = pges_pkg::S_ADDP;
                        n_q = '0; n_axis = 1'b1; n_neg = 1'b0;
                    end else begin
                        n_acc    = '0;
                        n_mcand  = AW'(n_root);
                        n_mplier = n_root;
                        n_cnt    = 8'(MW - 1);
                        n_state  = pges_pkg::S_RSQ;
                    end
                end
            end
            pges_pkg::S_DIV: begin
                n_acc  = {r_acc[AW-2:0], 1'b0};
                n_drem = d_ge ? (d_remt - {1'b0, r_den}) : d_remt;
                n_q    = {r_q[QW-2:0], d_ge};
                n_big  = r_big | r_q[QW-1];
                n_cnt  = r_cnt - 8'd1;
                if (r_cnt == 8'd0) begin
                    n_state = pges_pkg::S_ADDV;
                end
            end
            pges_pkg::S_ADDV: begin
                n_sat = r_sat | sat_res[CW];
                if (r_axis) begin
                    n_vy    = sat_res[CW-1:0];
                    n_state = pges_pkg::S_ADDP;
                    n_q = '0; n_neg = 1'b0;
                end else begin
                    n_vx     = sat_res[CW-1:0];
                    n_axis   = 1'b1;
                    n_acc    = '0;
                    n_mcand  = AW'(r_ay);
                    n_mplier = MW'(r_grav);
                    n_cnt    = 8'(pges_pkg::GW - 1);
                    n_state  = pges_pkg::S_NG;
                end
            end
            pges_pkg::S_ADDP: begin
                // the y step (zero but for a move) closes every item and hands the word out
                n_sat = r_sat | sat_res[CW];
                if (r_axis) begin
                    if (out_free) begin
                        n_py = sat_res[CW-1:0];
                        n_out.pos_x = r_px;
                        n_out.pos_y = sat_res[CW-1:0];
                        n_out.vel_x = r_vx;
                        n_out.vel_y = r_vy;
                        n_out.status = (r_skip != pges_pkg::ST_DONE) ? r_skip :
                                       (n_sat ? pges_pkg::ST_SATURATED
                                              : pges_pkg::ST_DONE);
                        n_out_valid = 1'b1;
                        n_state = pges_pkg::S_IDLE;
                    end else begin
                        n_sat = r_sat;
                    end
                end else begin
                    n_px     = sat_res[CW-1:0];
                    n_axis   = 1'b1;
                    n_acc    = '0;
                    n_mcand  = AW'(vmag_y);
                    n_mplier = MW'(r_dt);
                    n_cnt    = 8'(pges_pkg::DtW - 1);
                    n_neg    = r_vy[CW-1];
                    n_state  = pges_pkg::S_MOVE;
                end
            end
            default: begin
                // shift-add multiply states
                n_acc    = mul_acc;
                n_mcand  = {r_mcand[AW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[MW-1:1]};
                n_cnt    = r_cnt - 8'd1;
                if (r_cnt == 8'd0) begin
                    priority case (1'b1)
                        r_state == pges_pkg::S_R2X: begin
                            n_mcand  = AW'(r_ay);
                            n_mplier = r_ay;
                            n_cnt    = 8'(MW - 1);
                            n_state  = pges_pkg::S_R2Y;
                        end
                        r_state == pges_pkg::S_R2Y: begin
                            n_sq    = mul_acc[2*MW-1:0];
                            n_srem  = '0;
                            n_root  = '0;
                            n_cnt   = 8'(MW - 1);
                            n_state = pges_pkg::S_SQRT;
                        end
                        r_state == pges_pkg::S_RSQ: begin
                            n_acc    = '0;
                            n_mcand  = mul_acc;
                            n_mplier = r_root;
                            n_cnt    = 8'(MW - 1);
                            n_state  = pges_pkg::S_RCUBE;
                        end
                        r_state == pges_pkg::S_RCUBE: begin
                            n_den    = mul_acc[DW-1:0];
                            n_axis   = 1'b0;
                            n_acc    = '0;
                            n_mcand  = AW'(r_ax);
                            n_mplier = MW'(r_grav);
                            n_cnt    = 8'(pges_pkg::GW - 1);
                            n_state  = pges_pkg::S_NG;
                        end
                        r_state == pges_pkg::S_NG: begin
                            n_acc    = '0;
                            n_mcand  = mul_acc;
                            n_mplier = MW'(r_mass);
                            n_cnt    = 8'(pges_pkg::MassW - 1);
                            n_state  = pges_pkg::S_NM;
                        end
                        r_state == pges_pkg::S_NM: begin
                            n_acc    = '0;
                            n_mcand  = mul_acc;
                            n_mplier = MW'(r_dt);
                            n_cnt    = 8'(pges_pkg::DtW - 1);
                            n_state  = pges_pkg::S_NT;
                        end
                        r_state == pges_pkg::S_NT: begin
                            n_drem  = '0;
                            n_q     = '0;
                            n_big   = 1'b0;
                            n_cnt   = 8'(pges_pkg::DivSteps - 1);
                            n_state = pges_pkg::S_DIV;
                        end
                        default: begin
                            // move: drop the fraction of dt
                            n_q     = QW'(mul_acc[pges_pkg::DtW +: CW]);
                            n_state = pges_pkg::S_ADDP;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pges_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ipx <= '0; r_ipy <= '0; r_ivx <= '0; r_ivy <= '0;
            r_own_mass <= pges_pkg::MassW'(1);
            r_grav     <= pges_pkg::GW'(15);
            r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_px <= n_px; r_py <= n_py; r_vx <= n_vx; r_vy <= n_vy;
            if (i_cfg_we) begin
                unique case (pges_pkg::t_cfg_index'(i_cfg_index))
                    pges_pkg::CFG_POS_X: r_ipx <= i_cfg_data;
                    pges_pkg::CFG_POS_Y: r_ipy <= i_cfg_data;
                    pges_pkg::CFG_VEL_X: r_ivx <= i_cfg_data;
                    pges_pkg::CFG_VEL_Y: r_ivy <= i_cfg_data;
                    pges_pkg::CFG_MASS:  r_own_mass <= i_cfg_data;
                    pges_pkg::CFG_GRAV:  r_grav <= i_cfg_data[pges_pkg::GW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ox   <= i_in_word.other_pos_x;
            r_oy   <= i_in_word.other_pos_y;
            r_mass <= i_in_word.other_mass;
            r_dt   <= i_in_word.time_step;
        end
        r_acc <= n_acc; r_mcand <= n_mcand; r_mplier <= n_mplier; r_cnt <= n_cnt;
        r_ax <= n_ax; r_ay <= n_ay; r_negx <= n_negx; r_negy <= n_negy;
        r_neg <= n_neg; r_axis <= n_axis;
        r_sq <= n_sq; r_srem <= n_srem; r_root <= n_root;
        r_den <= n_den; r_drem <= n_drem; r_q <= n_q; r_big <= n_big;
        r_sat <= n_sat; r_skip <= n_skip;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pges_pkg::S_DIV) |-> (r_den != '0))
        else $error("divide by zero radius cubed");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != pges_pkg::S_IDLE))
        else $error("accepted word left no work");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pges_pkg::S_ADDP && r_axis && out_free) |=> o_out_valid)
        else $error("finished item gave no word");
`endif

endmodule
